[hw/rtl/cdq_pkg.sv]
package cdq_pkg;

  // storage geometry
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;

  // fixed field widths of the stream payloads
  localparam int CMD_WIDTH    = 2;
  localparam int WORD_WIDTH   = 32;
  localparam int STATUS_WIDTH = 2;
  localparam int S_TDATA_WIDTH = 40;
  localparam int M_TDATA_WIDTH = 40;

  // command codes on the input stream
  localparam logic [CMD_WIDTH-1:0] CMD_PUSH_FRONT = 2'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_PUSH_REAR  = 2'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_POP_FRONT  = 2'd2;
  localparam logic [CMD_WIDTH-1:0] CMD_POP_REAR   = 2'd3;

  // status codes on the output stream
  localparam logic [STATUS_WIDTH-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd2;

  // operation broadcast to every cell
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH_FRONT,
    OP_PUSH_REAR,
    OP_POP_FRONT,
    OP_POP_REAR
  } op_t;

  typedef logic [DATA_WIDTH-1:0] word_t;

  // control broadcast from the top level to the cells
  typedef struct packed {
    op_t   op;
    word_t word;
  } ctrl_t;

  // what one cell shows its neighbors
  typedef struct packed {
    logic  valid;
    word_t word;
  } link_t;

endpackage

[hw/rtl/cdq_cell.sv]
module cdq_cell (
  input  logic           clk,
  input  logic           rst,
  input  cdq_pkg::ctrl_t ctrl,
  input  cdq_pkg::link_t left,
  input  cdq_pkg::link_t right,
  input  cdq_pkg::word_t tap_in,
  output cdq_pkg::link_t self,
  output cdq_pkg::word_t tap_out
);
  import cdq_pkg::*;

  logic  valid;
  logic  valid_next;
  word_t word;
  word_t word_next;
  logic  is_rear;

  // this cell holds the last element when the one to the right is empty
  assign is_rear = valid && !right.valid;

  // rear word travels toward the front along the row
  assign tap_out = tap_in | (is_rear ? word : '0);

  // valid flag above the stored word
  assign self = {valid, word};

  // per-cell update: shift, fill the first empty cell, or drop the last one
  always_comb begin
    valid_next = valid;
    word_next  = word;
    case (ctrl.op)
      OP_PUSH_FRONT: begin
        valid_next = left.valid;
        word_next  = left.word;
      end
      OP_PUSH_REAR: begin
        if (left.valid && !valid) begin
          valid_next = 1'b1;
          word_next  = ctrl.word;
        end
      end
      OP_POP_FRONT: begin
        valid_next = right.valid;
        word_next  = right.word;
      end
      OP_POP_REAR: begin
        valid_next = valid && right.valid;
      end
      default: begin
        valid_next = valid;
        word_next  = word;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

[hw/rtl/circular_buffer_deque.sv]
// a result is registered and appears on the output stream in the cycle after its command is taken
// throughput: one command per cycle while the output side keeps up
// the contents sit in a row of cells that shift toward either end, so every
// command completes in the cycle in which it is taken
// reset (synchronous, active high) empties the queue and drops any pending result
module circular_buffer_deque (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // command[1:0], data_in[33:2], zero pad[39:34]
  input  logic [cdq_pkg::S_TDATA_WIDTH-1:0] s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // data_out[31:0], status[33:32], is_full[34], is_empty[35], zero pad[39:36]
  output logic [cdq_pkg::M_TDATA_WIDTH-1:0] m_tdata
);
  import cdq_pkg::*;

  logic [CMD_WIDTH-1:0]    command;
  logic [WORD_WIDTH-1:0]   data_in;
  logic                    accept;
  logic                    full;
  logic                    empty;
  logic                    is_push;
  logic                    ok;
  ctrl_t                   ctrl;
  link_t                   links [DEPTH];
  word_t                   taps  [DEPTH];
  logic [WORD_WIDTH-1:0]   data_out_next;
  logic [STATUS_WIDTH-1:0] status_next;
  logic                    is_full_next;
  logic                    is_empty_next;
  logic [WORD_WIDTH-1:0]   data_out;
  logic [STATUS_WIDTH-1:0] status;
  logic                    is_full;
  logic                    is_empty;

  // unpack the input transaction
  assign command = s_tdata[CMD_WIDTH-1:0];
  assign data_in = s_tdata[CMD_WIDTH +: WORD_WIDTH];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // occupancy is the thermometer of cell valid bits
  assign full    = links[DEPTH-1].valid;
  assign empty   = !links[0].valid;
  assign is_push = (command == CMD_PUSH_FRONT) || (command == CMD_PUSH_REAR);
  assign ok      = is_push ? !full : !empty;

  // operation for the cells, only on an accepted command that is not rejected
  always_comb begin
    ctrl.word = data_in[DATA_WIDTH-1:0];
    ctrl.op   = OP_HOLD;
    if (accept && ok) begin
      case (command)
        CMD_PUSH_FRONT: ctrl.op = OP_PUSH_FRONT;
        CMD_PUSH_REAR:  ctrl.op = OP_PUSH_REAR;
        CMD_POP_FRONT:  ctrl.op = OP_POP_FRONT;
        CMD_POP_REAR:   ctrl.op = OP_POP_REAR;
        default:        ctrl.op = OP_HOLD;
      endcase
    end
  end

  // row of cells, the front element in cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    link_t left;
    link_t right;
    word_t tap_in;

    if (i == 0) begin : g_first
      assign left = {1'b1, ctrl.word};
    end else begin : g_inner_left
      assign left = links[i-1];
    end

    if (i == DEPTH-1) begin : g_last
      assign right  = '0;
      assign tap_in = '0;
    end else begin : g_inner_right
      assign right  = links[i+1];
      assign tap_in = taps[i+1];
    end

    cdq_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .left    (left),
      .right   (right),
      .tap_in  (tap_in),
      .self    (links[i]),
      .tap_out (taps[i])
    );
  end

  // result of the command as it stands after the step
  always_comb begin
    data_out_next = '0;
    status_next   = STATUS_DONE;
    is_full_next  = full;
    is_empty_next = empty;
    if (is_push) begin
      if (full) begin
        status_next = STATUS_FULL;
      end else begin
        is_empty_next = 1'b0;
        is_full_next  = links[DEPTH-2].valid;
      end
    end else begin
      if (empty) begin
        status_next = STATUS_EMPTY;
      end else begin
        is_full_next  = 1'b0;
        is_empty_next = !links[1].valid;
        if (command == CMD_POP_FRONT) begin
          data_out_next = WORD_WIDTH'(links[0].word);
        end else begin
          data_out_next = WORD_WIDTH'(taps[0]);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_out <= data_out_next;
      status   <= status_next;
      is_full  <= is_full_next;
      is_empty <= is_empty_next;
    end
  end

  // pack the output transaction
  assign m_tdata = {4'b0000, is_empty, is_full, status, data_out};

endmodule
